// ===== rtl/core/mme_pkg.sv =====
// Shared types, constants and helpers for the matrix multiply engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mme_pkg;

    // Storage geometry and element width
    localparam int MAX_DIM    = 16;
    localparam int DATA_WIDTH = 16;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
    localparam int PROD_W = 2 * DATA_WIDTH;

    // Fixed field widths of the request and result
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 36;
    localparam int CFG_W   = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Request modes
    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(16);

    typedef struct packed {
        logic [1:0]                mode;
        logic [3:0]                row;
        logic [3:0]                col;
        logic signed [VALUE_W-1:0] value;
    } mme_req_t;

    typedef struct packed {
        logic [3:0]              result_row;
        logic [3:0]              result_col;
        logic signed [SUM_W-1:0] product_sum;
        logic                    last;
    } mme_res_t;

    // Effective dimensions, clamped to the store size
    typedef struct packed {
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] inner;
        logic [CNT_W-1:0] cols;
    } mme_dims_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                      load_a;
        logic                      load_b;
        logic [ADDR_W-1:0]         load_addr;
        logic signed [VALUE_W-1:0] load_value;
        logic                      issue;
        logic [ADDR_W-1:0]         a_addr;
        logic [ADDR_W-1:0]         b_addr;
        logic                      first_term;
        logic                      last_term;
        logic                      zero_term;
        logic                      last_col;
        logic [3:0]                out_row;
        logic [3:0]                out_col;
    } mme_cmd_t;

    typedef struct packed {
        logic pipe_busy;
    } mme_status_t;

    // Keep the low DATA_WIDTH bits of a sign-extended field value
    function automatic logic signed [DATA_WIDTH-1:0] to_elem(
        input logic signed [VALUE_W-1:0] v
    );
        logic signed [31:0] w;
        w = 32'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Clamp a register value to the store dimension
    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (int'(v) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/matrix_multiply_engine_unit.sv =====
// Top level of the matrix multiply engine: register port, controller and
// datapath. Depends on mme_pkg, mme_regs, mme_ctrl and mme_datapath.
`default_nettype none

// Computes one row of C = A * B per compute request on signed Q2.14
// elements, with exact Q8.28 sums in 36 bits. A request is taken at a rising
// edge with start high and busy low. Load requests (A or B element) leave
// busy low, so loads may follow back to back. A compute request for a row
// below rows_a with cols_b nonzero keeps busy high while one shared
// multiply-accumulate unit reads one A and one B element per cycle from the
// two single-read stores, and while a three-stage read/multiply/accumulate
// pipeline drains at the end. A compute request for a row at or past rows_a
// or with cols_b zero, and mode 3, return at once with no result. Results
// appear in column order, each for exactly one cycle on result with
// result_valid high; the receiver cannot hold them off, so it must take
// every strobe. last marks the final column. Stores are not cleared: read
// only elements that were written. Registers rows_a, inner_dim and cols_b
// sit at byte addresses 0, 4 and 8; write them only while busy is low and
// no result is pending.
module matrix_multiply_engine_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire mme_pkg::mme_req_t              request,
    output logic                                result_valid,
    output mme_pkg::mme_res_t                   result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mme_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [mme_pkg::PDATA_W-1:0]    pwdata,
    output logic      [mme_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready
);
    import mme_pkg::*;

    mme_dims_t   dims;
    mme_cmd_t    cmd;
    mme_status_t status;

    // Hold the configuration and present the clamped dimensions
    mme_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    // Decode requests and step through columns and inner terms
    mme_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .dims    (dims),
        .status  (status),
        .busy    (busy),
        .cmd     (cmd)
    );

    // Store elements and run the multiply-accumulate pipeline
    mme_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mme_regs.sv =====
// APB-style configuration registers of the matrix multiply engine.
// Depends on mme_pkg for widths, register indexes and the dimension clamp.
`default_nettype none

module mme_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [mme_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [mme_pkg::PDATA_W-1:0]    pwdata,
    output logic      [mme_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    output mme_pkg::mme_dims_t                  dims
);
    import mme_pkg::*;

    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ROWS_A:    rows_a_reg    <= pwdata[CFG_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[CFG_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ROWS_A:    prdata = PDATA_W'(rows_a_reg);
            REG_INNER_DIM: prdata = PDATA_W'(inner_dim_reg);
            REG_COLS_B:    prdata = PDATA_W'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    assign dims.rows  = clamp_dim(rows_a_reg);
    assign dims.inner = clamp_dim(inner_dim_reg);
    assign dims.cols  = clamp_dim(cols_b_reg);

endmodule

`default_nettype wire

// ===== rtl/core/mme_ctrl.sv =====
// Controller of the matrix multiply engine: decodes requests, sequences
// the column and inner loops of a row. Depends on mme_pkg.
`default_nettype none

module mme_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire mme_pkg::mme_req_t    request,
    input  wire mme_pkg::mme_dims_t   dims,
    input  wire mme_pkg::mme_status_t status,
    output logic                      busy,
    output mme_pkg::mme_cmd_t         cmd
);
    import mme_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] l_reg, l_next;

    logic accept;
    logic in_range;
    logic run_ok;
    logic zero_k;
    logic last_term;
    logic last_col;

    assign accept   = start && !busy;
    assign in_range = (int'(request.row) < MAX_DIM) && (int'(request.col) < MAX_DIM);
    assign run_ok   = (int'(request.row) < int'(dims.rows)) && (dims.cols != '0);
    assign zero_k   = (dims.inner == '0);
    assign last_term = zero_k || ((CNT_W'(l_reg) + CNT_W'(1)) == dims.inner);
    assign last_col  = (CNT_W'(j_reg) + CNT_W'(1)) == dims.cols;
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            j_reg     <= '0;
            l_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            l_reg     <= l_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        l_next     = l_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.mode == MODE_COMPUTE) && run_ok)
                begin
                    row_next   = IDX_W'(request.row);
                    j_next     = '0;
                    l_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // advance the inner index, then the column
                if (last_term)
                begin
                    l_next = '0;
                    if (last_col)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    l_next = l_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load_a     = accept && (request.mode == MODE_LOAD_A) && in_range;
        cmd.load_b     = accept && (request.mode == MODE_LOAD_B) && in_range;
        cmd.load_addr  = ADDR_W'(ADDR_W'(request.row) * ADDR_W'(MAX_DIM)
                                 + ADDR_W'(request.col));
        cmd.load_value = request.value;
        cmd.issue      = (state_reg == ST_RUN);
        cmd.a_addr     = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(l_reg));
        cmd.b_addr     = ADDR_W'(ADDR_W'(l_reg) * ADDR_W'(MAX_DIM) + ADDR_W'(j_reg));
        cmd.first_term = (l_reg == '0);
        cmd.last_term  = last_term;
        cmd.zero_term  = zero_k;
        cmd.last_col   = last_col;
        cmd.out_row    = 4'(row_reg);
        cmd.out_col    = 4'(j_reg);
    end

endmodule

`default_nettype wire

// ===== rtl/core/mme_datapath.sv =====
// Datapath of the matrix multiply engine: A and B stores, the shared
// multiply-accumulate pipeline and the result register. Depends on mme_pkg.
`default_nettype none

module mme_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mme_pkg::mme_cmd_t cmd,
    output mme_pkg::mme_status_t   status,
    output logic                   result_valid,
    output mme_pkg::mme_res_t      result
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef struct packed {
        logic       first_term;
        logic       last_term;
        logic       zero_term;
        logic       last_col;
        logic [3:0] out_row;
        logic [3:0] out_col;
    } meta_t;

    logic signed [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] b_mem [DEPTH];

    logic signed [DATA_WIDTH-1:0] a_q_reg;
    logic signed [DATA_WIDTH-1:0] b_q_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [SUM_W-1:0]      acc_reg;
    meta_t                        meta1_reg;
    meta_t                        meta2_reg;
    logic                         v1_reg;
    logic                         v2_reg;
    logic                         res_valid_reg;
    mme_res_t                     res_reg;

    logic signed [SUM_W-1:0] prod_ext;
    logic signed [SUM_W-1:0] sum_next;

    // Store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            a_mem[cmd.load_addr] <= to_elem(cmd.load_value);
        end
        if (cmd.load_b)
        begin
            b_mem[cmd.load_addr] <= to_elem(cmd.load_value);
        end
        if (cmd.issue)
        begin
            a_q_reg <= a_mem[cmd.a_addr];
            b_q_reg <= b_mem[cmd.b_addr];
        end
    end

    assign prod_ext = SUM_W'(prod_reg);
    assign sum_next = meta2_reg.first_term ? prod_ext : SUM_W'(acc_reg + prod_ext);

    // Multiply and accumulate stages
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            meta1_reg.first_term <= cmd.first_term;
            meta1_reg.last_term  <= cmd.last_term;
            meta1_reg.zero_term  <= cmd.zero_term;
            meta1_reg.last_col   <= cmd.last_col;
            meta1_reg.out_row    <= cmd.out_row;
            meta1_reg.out_col    <= cmd.out_col;
        end
        if (v1_reg)
        begin
            meta2_reg <= meta1_reg;
            prod_reg  <= meta1_reg.zero_term ? '0 : PROD_W'(a_q_reg * b_q_reg);
        end
        if (v2_reg)
        begin
            acc_reg <= sum_next;
            if (meta2_reg.last_term)
            begin
                res_reg.result_row  <= meta2_reg.out_row;
                res_reg.result_col  <= meta2_reg.out_col;
                res_reg.product_sum <= sum_next;
                res_reg.last        <= meta2_reg.last_col;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            res_valid_reg <= v2_reg && meta2_reg.last_term;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg;
    assign result_valid     = res_valid_reg;
    assign result           = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mme_checker.sv =====
// Port-level checks of the matrix multiply engine, bound to its top level.
// Depends on mme_pkg and matrix_multiply_engine_unit.
`default_nettype none

module mme_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire mme_pkg::mme_req_t request,
    input wire logic              result_valid,
    input wire mme_pkg::mme_res_t result
);
    import mme_pkg::*;

    // A compute request never yields a result in the very next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.mode == MODE_COMPUTE)) |=> !result_valid)
        else $error("result one cycle after compute request");

    // More columns pending keeps the block busy
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("idle while a row is unfinished");

    // A row ends with a gap before any further result
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result right after the last of a row");

    // Back-to-back results step one column within the same row
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(result_valid)) |->
            ((result.result_col == 4'($past(result.result_col) + 4'd1)) &&
             (result.result_row == $past(result.result_row))))
        else $error("results out of column order");

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for matrix_multiply_engine_unit: loads elements of A and B,
// requests result rows and checks every strobed element against a row-product scoreboard.
// Depends on mme_pkg and the engine RTL; needs nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    // Mode code the engine leaves unused: accepted and dropped
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Cycles with no handshake of any kind before the run is declared hung.
    // The slowest legal stretch is a 16x16 compute or a long sender gap.
    localparam int STALL_LIMIT  = 2000;
    // Pipeline drain allowance after busy drops (three stages plus margin)
    localparam int DRAIN_CYCLES = 8;
    // Stimulus length of the random part, not counting dropped requests
    localparam int RANDOM_ITEMS = 100;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors both element stores and the dimension registers,
    // predicts every element of a requested row and holds them in order.
    // ------------------------------------------------------------------
    class matmul_scoreboard;
        logic signed [VALUE_W-1:0] a_elem [MAX_DIM*MAX_DIM];
        logic signed [VALUE_W-1:0] b_elem [MAX_DIM*MAX_DIM];
        bit                        a_written [MAX_DIM*MAX_DIM];
        bit                        b_written [MAX_DIM*MAX_DIM];
        logic [CFG_W-1:0]          dim_reg [3];
        mme_res_t                  due_elems [$];
        int                        errors;

        function new();
            foreach (a_written[i])
            begin
                a_written[i] = 1'b0;
                b_written[i] = 1'b0;
            end
            dim_reg[REG_ROWS_A]    = DIM_RESET;
            dim_reg[REG_INNER_DIM] = DIM_RESET;
            dim_reg[REG_COLS_B]    = DIM_RESET;
            errors = 0;
        endfunction

        // Register value as the engine uses it: anything past the store
        // size counts as the store size.
        function int eff(input logic [1:0] idx);
            return (int'(dim_reg[idx]) > MAX_DIM) ? MAX_DIM : int'(dim_reg[idx]);
        endfunction

        // Find the first store entry that computing this row would read while
        // it was never written. Returns 0 when the row is safe to request.
        function bit next_missing(input logic [3:0] row, output logic [1:0] mode,
                                  output logic [3:0] r, output logic [3:0] c);
            int k;
            int n;
            k = eff(REG_INNER_DIM);
            n = eff(REG_COLS_B);
            mode = MODE_COMPUTE;
            r = row;
            c = '0;
            if (int'(row) >= eff(REG_ROWS_A) || n == 0)
            begin
                return 1'b0;
            end
            for (int l = 0; l < k; l++)
            begin
                if (!a_written[int'(row)*MAX_DIM + l])
                begin
                    mode = MODE_LOAD_A;
                    c = 4'(l);
                    return 1'b1;
                end
            end
            for (int l = 0; l < k; l++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (!b_written[l*MAX_DIM + j])
                    begin
                        mode = MODE_LOAD_B;
                        r = 4'(l);
                        c = 4'(j);
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        // Apply one accepted request: store a load, or queue the row it computes
        function void note_request(input mme_req_t q);
            int       addr;
            int       m;
            int       k;
            int       n;
            longint   acc;
            mme_res_t e;
            addr = int'(q.row)*MAX_DIM + int'(q.col);
            case (q.mode)
                MODE_LOAD_A:
                begin
                    a_elem[addr]    = q.value;
                    a_written[addr] = 1'b1;
                end
                MODE_LOAD_B:
                begin
                    b_elem[addr]    = q.value;
                    b_written[addr] = 1'b1;
                end
                MODE_COMPUTE:
                begin
                    m = eff(REG_ROWS_A);
                    k = eff(REG_INNER_DIM);
                    n = eff(REG_COLS_B);
                    if (int'(q.row) < m)
                    begin
                        for (int j = 0; j < n; j++)
                        begin
                            acc = 0;
                            for (int l = 0; l < k; l++)
                            begin
                                acc += longint'(a_elem[int'(q.row)*MAX_DIM + l]) *
                                       longint'(b_elem[l*MAX_DIM + j]);
                            end
                            e.result_row  = q.row;
                            e.result_col  = 4'(j);
                            e.product_sum = acc[SUM_W-1:0];
                            e.last        = (j == n - 1);
                            due_elems.push_back(e);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(input string msg);
            $display("tb_top mismatch at %0t ns: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one strobed element with the oldest prediction, field by field
        task check_result(input mme_res_t got);
            mme_res_t want;
            if (due_elems.size() == 0)
            begin
                report($sformatf("unexpected element row %0d col %0d sum %0d",
                                 got.result_row, got.result_col, got.product_sum));
                return;
            end
            want = due_elems.pop_front();
            if (got.result_row !== want.result_row)
            begin
                report($sformatf("result_row %0d, want %0d",
                                 got.result_row, want.result_row));
            end
            if (got.result_col !== want.result_col)
            begin
                report($sformatf("result_col %0d, want %0d (row %0d)",
                                 got.result_col, want.result_col, want.result_row));
            end
            if (got.product_sum !== want.product_sum)
            begin
                report($sformatf("product_sum %0d, want %0d (row %0d col %0d)",
                                 got.product_sum, want.product_sum,
                                 want.result_row, want.result_col));
            end
            if (got.last !== want.last)
            begin
                report($sformatf("last %b, want %b (row %0d col %0d)", got.last,
                                 want.last, want.result_row, want.result_col));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and every block input start from known values
    // ------------------------------------------------------------------
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    mme_req_t           request = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic               busy;
    logic               result_valid;
    mme_res_t           result;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    matmul_scoreboard sb;
    int               idle_cycles = 0;
    int               sent_items  = 0;

    always #2 clk = ~clk;

    matrix_multiply_engine_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Take every strobe: the receiver has no way to stall the engine
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            sb.check_result(result);
        end
    end

    // Watchdog: count cycles in which no request, element or register
    // transfer moves, and abort the run once the count reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable && pready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Setup and access phases, then an idle wait so the next transfer
    // never assigns psel in the same step as this one lowers it.
    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        // Sample the read data at the edge that closes the access cycle
        d = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_dim_check(input logic [1:0] idx);
        logic [PDATA_W-1:0] got;
        apb_read(PADDR_W'({idx, 2'b00}), got);
        if (got[CFG_W-1:0] !== sb.dim_reg[idx])
        begin
            sb.report($sformatf("register %0d reads %0d, want %0d", idx,
                                got[CFG_W-1:0], sb.dim_reg[idx]));
        end
    endtask

    // Write one dimension register with junk in the unused upper bits, mirror
    // the stored field and read it back.
    task automatic program_dim(input logic [1:0] idx, input logic [CFG_W-1:0] v);
        logic [PDATA_W-1:0] word;
        word = ($urandom() & ~PDATA_W'({CFG_W{1'b1}})) | PDATA_W'(v);
        apb_write(PADDR_W'({idx, 2'b00}), word);
        sb.dim_reg[idx] = v;
        read_dim_check(idx);
    endtask

    task automatic program_dims(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                                input logic [CFG_W-1:0] n);
        program_dim(REG_ROWS_A, m);
        program_dim(REG_INNER_DIM, k);
        program_dim(REG_COLS_B, n);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Hold start and the request until an edge sees busy low; start is left
    // high so a back-to-back request keeps it up without a glitch.
    task automatic send_request(input mme_req_t r);
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_request(r);
        if (r.mode != MODE_UNUSED)
        begin
            sent_items++;
        end
    endtask

    // Random idle time between requests: mostly none, some short, a few long
    task automatic sender_gap(input bit quiet);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
        begin
            gap = 0;
        end
        else if (roll < 95)
        begin
            gap = $urandom_range(1, 4);
        end
        else
        begin
            gap = $urandom_range(10, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [1:0] mode, input int row, input int col,
                             input logic signed [VALUE_W-1:0] value, input bit quiet);
        mme_req_t r;
        r.mode  = mode;
        r.row   = 4'(row);
        r.col   = 4'(col);
        r.value = value;
        send_request(r);
        sender_gap(quiet);
    endtask

    // Drop start, wait for every predicted element and for busy to fall,
    // then let the pipeline drain before anything touches the registers.
    task automatic settle();
        start <= 1'b0;
        while (sb.due_elems.size() != 0) @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    // Mostly inside the configured size, sometimes anywhere in the store
    function automatic logic [3:0] pick_index(input int lim);
        if (lim > 0 && $urandom_range(0, 9) < 7)
        begin
            return 4'($urandom_range(0, lim - 1));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    // Dimension register values: mostly small, with zero and past-the-store
    // values mixed in.
    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(17, 31));
            2: return CFG_W'($urandom_range(5, 16));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Half loads, most of the rest row computes; a compute whose operands
    // are not all written yet turns into the load it is missing, so rows
    // fill up and get computed instead of stalling on unwritten entries.
    function automatic mme_req_t random_request();
        mme_req_t   r;
        int         roll;
        logic [1:0] fix_mode;
        logic [3:0] fix_row;
        logic [3:0] fix_col;
        r.row   = 4'($urandom());
        r.col   = 4'($urandom());
        r.value = pick_value();
        roll    = $urandom_range(0, 99);
        if (roll < 50)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                r.mode = MODE_LOAD_A;
                r.row  = pick_index(sb.eff(REG_ROWS_A));
                r.col  = pick_index(sb.eff(REG_INNER_DIM));
            end
            else
            begin
                r.mode = MODE_LOAD_B;
                r.row  = pick_index(sb.eff(REG_INNER_DIM));
                r.col  = pick_index(sb.eff(REG_COLS_B));
            end
        end
        else if (roll < 90)
        begin
            r.mode = MODE_COMPUTE;
            if ($urandom_range(0, 99) < 85)
            begin
                r.row = pick_index(sb.eff(REG_ROWS_A));
            end
            if (sb.next_missing(r.row, fix_mode, fix_row, fix_col))
            begin
                r.mode = fix_mode;
                r.row  = fix_row;
                r.col  = fix_col;
            end
        end
        else
        begin
            r.mode = MODE_UNUSED;
        end
        return r;
    endfunction

    task automatic run_random_phase(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                                    input logic [CFG_W-1:0] n);
        int  count;
        bit  quiet;
        program_dims(m, k, n);
        // Some phases run back to back with no gaps at all
        quiet = ($urandom_range(0, 3) == 0);
        count = $urandom_range(8, 20);
        repeat (count)
        begin
            send_request(random_request());
            sender_gap(quiet);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Directed part: 2x2x2 with extreme operands, loads outside the size,
    // rows past rows_a, the unused mode and junk fields on a compute.
    // ------------------------------------------------------------------
    task automatic run_directed();
        program_dims(CFG_W'(2), CFG_W'(2), CFG_W'(2));
        send_item(MODE_LOAD_A, 0, 0, 16'sh8000, 1'b0);
        send_item(MODE_LOAD_A, 0, 1, 16'sh8000, 1'b0);
        send_item(MODE_LOAD_A, 1, 0, 16'sh7FFF, 1'b0);
        send_item(MODE_LOAD_A, 1, 1, 16'sh0001, 1'b0);
        send_item(MODE_LOAD_B, 0, 0, 16'sh7FFF, 1'b0);
        send_item(MODE_LOAD_B, 0, 1, 16'sh8000, 1'b0);
        send_item(MODE_LOAD_B, 1, 0, 16'sh7FFF, 1'b0);
        send_item(MODE_LOAD_B, 1, 1, 16'sh8000, 1'b0);
        // Stored even though outside the configured size
        send_item(MODE_LOAD_A, 15, 15, 16'sh7FFF, 1'b0);
        send_item(MODE_LOAD_B, 15, 0, 16'shFFFF, 1'b0);
        send_item(MODE_COMPUTE, 0, 0, 16'sh0000, 1'b0);
        send_item(MODE_COMPUTE, 1, 0, 16'sh0000, 1'b0);
        // Rows at and past rows_a emit nothing
        send_item(MODE_COMPUTE, 2, 0, 16'sh0000, 1'b0);
        send_item(MODE_COMPUTE, 15, 15, 16'sh7FFF, 1'b0);
        send_item(MODE_UNUSED, 15, 15, 16'shFFFF, 1'b0);
        // col and value are ignored when computing
        send_item(MODE_COMPUTE, 1, 15, 16'shFFFF, 1'b0);
        // Overwrite an element and recompute back to back
        send_item(MODE_LOAD_A, 0, 1, 16'sh7FFF, 1'b1);
        send_item(MODE_COMPUTE, 0, 9, 16'sh1234, 1'b1);
        send_item(MODE_COMPUTE, 1, 3, 16'sh8000, 1'b0);
        settle();
    endtask

    // Full 16x16x16: all of B and row 0 of A at the most negative value give
    // the largest sum; row 1 at the most positive gives the most negative.
    task automatic run_full_phase();
        program_dims(CFG_W'(16), CFG_W'(16), CFG_W'(16));
        for (int l = 0; l < MAX_DIM; l++)
        begin
            for (int j = 0; j < MAX_DIM; j++)
            begin
                send_item(MODE_LOAD_B, l, j, 16'sh8000, ($urandom_range(0, 3) != 0));
            end
        end
        for (int l = 0; l < MAX_DIM; l++)
        begin
            send_item(MODE_LOAD_A, 0, l, 16'sh8000, 1'b1);
            send_item(MODE_LOAD_A, 1, l, 16'sh7FFF, 1'b1);
        end
        send_item(MODE_COMPUTE, 0, 0, 16'sh0000, 1'b0);
        send_item(MODE_COMPUTE, 1, 0, 16'sh0000, 1'b0);
        repeat (40)
        begin
            send_request(random_request());
            sender_gap(1'b0);
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int base;
        sb = new();
        // Hold reset, release it once, and never again
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Reset values of the dimension registers
        read_dim_check(REG_ROWS_A);
        read_dim_check(REG_INNER_DIM);
        read_dim_check(REG_COLS_B);

        run_directed();

        // Zero inner size, zero rows, zero columns, then each register past
        // the store size on its own
        base = sent_items;
        run_random_phase(CFG_W'(2), CFG_W'(0), CFG_W'(2));
        run_random_phase(CFG_W'(0), CFG_W'(2), CFG_W'(2));
        run_random_phase(CFG_W'(2), CFG_W'(2), CFG_W'(0));
        run_random_phase(CFG_W'(31), CFG_W'(2), CFG_W'(1));
        run_random_phase(CFG_W'(1), CFG_W'(31), CFG_W'(1));
        run_random_phase(CFG_W'(1), CFG_W'(1), CFG_W'(31));
        run_random_phase(CFG_W'(1), CFG_W'(1), CFG_W'(1));
        while (sent_items - base < RANDOM_ITEMS)
        begin
            run_random_phase(pick_dim(), pick_dim(), pick_dim());
        end

        run_full_phase();

        if (sb.errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mme_pkg.sv
rtl/core/mme_regs.sv
rtl/core/mme_ctrl.sv
rtl/core/mme_datapath.sv
rtl/core/matrix_multiply_engine_unit.sv
rtl/core/mme_checker.sv
tb/tb_top.sv
